// ----- hdl/prrs_pkg.sv -----
`timescale 1ns / 1ps

package prrs_pkg;

  // Operation codes carried in the input beat
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } op_e_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARV_THRESH = 1'b1;
  localparam int CFG_DATA_W = 32;

  // Field widths fixed by the interface
  localparam int TASK_ID_W   = 6;
  localparam int PRIORITY_W  = 3;
  localparam int NUM_LEVELS_W = 4;
  localparam int TICK_W      = 32;

  typedef struct packed {
    op_e_t                 operation;
    logic [TASK_ID_W-1:0]  task_id;
    logic [PRIORITY_W-1:0] task_priority;
    logic                  current_present;
  } in_item_t;

  typedef struct packed {
    logic                 next_valid;
    logic [TASK_ID_W-1:0] next_task_id;
    logic                 promoted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_LINK,
    ST_RESP
  } state_e_t;

endpackage

// ----- hdl/priority_round_robin_scheduler.sv -----
`timescale 1ns / 1ps

// Multilevel priority scheduler: one FIFO of task ids per level (level 0
// highest), kept as linked lists in a link memory, with a second memory
// holding a queued flag and a level per task. Insert appends a task at its
// level, schedule requeues the current task and dequeues from the highest
// non-empty level, and tick ages every waiting task up one level once the
// tick count passes the threshold. Insert, tick and no-op go through the
// task-memory lookup to the output register; schedule adds the pop and
// its synchronous link read, the link read being skipped when no level in
// use holds a task. The next beat is accepted while a result still waits
// at the output. After reset the block clears the task memory, one entry
// a cycle, before it accepts its first beat; configuration writes are
// taken at any time.
module priority_round_robin_scheduler #(
  parameter int MAX_TASKS  = 64,
  parameter int MAX_LEVELS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  prrs_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output prrs_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [prrs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW  = $clog2(MAX_TASKS);
  localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int TMW = LW + 1;
  localparam logic [IW-1:0] LAST_TASK = IW'(MAX_TASKS - 1);

  // Control and configuration state
  prrs_pkg::state_e_t state_r, state_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  logic [IW-1:0]  head_r  [MAX_LEVELS];
  logic [IW-1:0]  head_nxt[MAX_LEVELS];
  logic [IW-1:0]  tail_r  [MAX_LEVELS];
  logic [IW-1:0]  tail_nxt[MAX_LEVELS];
  logic [CW-1:0]  count_r  [MAX_LEVELS];
  logic [CW-1:0]  count_nxt[MAX_LEVELS];
  logic [prrs_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [prrs_pkg::NUM_LEVELS_W-1:0] num_levels_r;
  logic [prrs_pkg::TICK_W-1:0] thresh_r;
  logic out_valid_r, out_valid_nxt;

  // Payload registers
  prrs_pkg::in_item_t  item_r, item_nxt;
  prrs_pkg::out_item_t res_r, res_nxt;
  prrs_pkg::out_item_t out_data_r, out_data_nxt;
  logic [LW-1:0] pick_r, pick_nxt;
  logic [IW-1:0] hid_r, hid_nxt;

  // Memories
  logic [IW-1:0]  link_mem [MAX_TASKS];
  logic [TMW-1:0] task_mem [MAX_TASKS];
  logic           lm_we;
  logic [IW-1:0]  lm_wa, lm_wd, lm_ra, lm_rd_r;
  logic           tm_we;
  logic [IW-1:0]  tm_wa, tm_ra;
  logic [TMW-1:0] tm_wd, tm_rd_r;

  // Derived values
  logic [31:0] lv32, in_id32, item_id32, hid32, prio32, stored32, lvl32;
  logic [IW-1:0] in_id, item_id;
  logic id_ok, item_queued, out_free, finish;
  logic push_en;
  logic [LW-1:0] push_lvl;
  prrs_pkg::out_item_t res;
  logic [MAX_LEVELS-1:0] nonempty;
  logic found;
  logic [LW-1:0] pick;
  int jn;

  // Clamp the configured level count into 1..MAX_LEVELS
  always_comb begin
    lv32 = 32'(num_levels_r);
    if (lv32 == 32'd0) begin
      lv32 = 32'd1;
    end else if (lv32 > 32'(MAX_LEVELS)) begin
      lv32 = 32'(MAX_LEVELS);
    end
  end

  assign in_id32   = 32'(in_data.task_id);
  assign in_id     = in_id32[IW-1:0];
  assign item_id32 = 32'(item_r.task_id);
  assign item_id   = item_id32[IW-1:0];
  assign hid32     = 32'(hid_r);
  assign id_ok     = item_id32 < 32'(MAX_TASKS);
  assign item_queued = tm_rd_r[LW];
  assign prio32    = 32'(item_r.task_priority);
  assign stored32  = 32'(tm_rd_r[LW-1:0]);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != prrs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Pick the highest non-empty level in use
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int j = 0; j < MAX_LEVELS; j++) begin
      nonempty[j] = (32'(j) < lv32) && (count_r[j] != '0);
    end
    for (int j = MAX_LEVELS - 1; j >= 0; j--) begin
      if (nonempty[j]) begin
        found = 1'b1;
        pick  = LW'(j);
      end
    end
  end

  // Push target level for insert and requeue
  always_comb begin
    lvl32 = 32'd0;
    push_en = 1'b0;
    if (item_r.operation == prrs_pkg::OP_INSERT) begin
      lvl32   = (prio32 < lv32) ? prio32 : (lv32 - 32'd1);
      push_en = id_ok && !item_queued;
    end else if (item_r.operation == prrs_pkg::OP_SCHEDULE) begin
      lvl32   = (stored32 < lv32) ? stored32 : (lv32 - 32'd1);
      push_en = item_r.current_present && id_ok && !item_queued;
    end
    push_lvl = lvl32[LW-1:0];
  end

  // Next state, list updates and memory accesses
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    tick_nxt      = tick_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    pick_nxt      = pick_r;
    hid_nxt       = hid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    res           = '0;
    finish        = 1'b0;
    lm_we = 1'b0;
    lm_wa = '0;
    lm_wd = '0;
    lm_ra = '0;
    tm_we = 1'b0;
    tm_wa = '0;
    tm_wd = '0;
    tm_ra = in_id;
    jn    = 0;

    unique case (state_r)
      prrs_pkg::ST_CLEAR: begin
        // Sweep the task memory so every queued flag starts clear
        tm_we = 1'b1;
        tm_wa = clr_r;
        if (clr_r == LAST_TASK) begin
          state_nxt = prrs_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      prrs_pkg::ST_IDLE: begin
        // Latch the beat and look up its task entry
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = prrs_pkg::ST_EXEC;
        end
      end

      prrs_pkg::ST_EXEC: begin
        // Append to the chosen level
        if (push_en) begin
          tm_we = 1'b1;
          tm_wa = item_id;
          tm_wd = {1'b1, push_lvl};
          if (count_r[push_lvl] != '0) begin
            lm_we = 1'b1;
            lm_wa = tail_r[push_lvl];
            lm_wd = item_id;
          end else begin
            head_nxt[push_lvl] = item_id;
          end
          tail_nxt[push_lvl]  = item_id;
          count_nxt[push_lvl] = count_r[push_lvl] + 1'b1;
        end
        unique case (item_r.operation)
          prrs_pkg::OP_INSERT: begin
            finish = 1'b1;
          end
          prrs_pkg::OP_SCHEDULE: begin
            state_nxt = prrs_pkg::ST_POP;
          end
          prrs_pkg::OP_TICK: begin
            // Age all waiting tasks up one level
            if (tick_r > thresh_r) begin
              res.promoted = 1'b1;
              for (int j = 0; j < MAX_LEVELS; j++) begin
                jn = (j < MAX_LEVELS - 1) ? j + 1 : j;
                if (32'(j + 1) < lv32) begin
                  if (j == 0 && count_r[0] != '0) begin
                    if (count_r[jn] != '0) begin
                      lm_we       = 1'b1;
                      lm_wa       = tail_r[0];
                      lm_wd       = head_r[jn];
                      tail_nxt[0] = tail_r[jn];
                    end
                    count_nxt[0] = count_r[0] + count_r[jn];
                  end else begin
                    head_nxt[j]  = head_r[jn];
                    tail_nxt[j]  = tail_r[jn];
                    count_nxt[j] = count_r[jn];
                  end
                end else if (j >= 1 && 32'(j + 1) == lv32) begin
                  count_nxt[j] = '0;
                end
              end
            end
            if (tick_r != '1) begin
              tick_nxt = tick_r + 1'b1;
            end
            finish = 1'b1;
          end
          prrs_pkg::OP_NOP: begin
            finish = 1'b1;
          end
        endcase
      end

      prrs_pkg::ST_POP: begin
        // Take the head of the highest non-empty level
        if (found) begin
          lm_ra = head_r[pick];
          tm_we = 1'b1;
          tm_wa = head_r[pick];
          tm_wd = {1'b0, pick};
          count_nxt[pick] = count_r[pick] - 1'b1;
          pick_nxt  = pick;
          hid_nxt   = head_r[pick];
          state_nxt = prrs_pkg::ST_LINK;
        end else begin
          finish = 1'b1;
        end
      end

      prrs_pkg::ST_LINK: begin
        // Advance the head to the linked successor
        head_nxt[pick_r]  = lm_rd_r;
        res.next_valid    = 1'b1;
        res.next_task_id  = hid32[prrs_pkg::TASK_ID_W-1:0];
        finish            = 1'b1;
      end

      prrs_pkg::ST_RESP: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = prrs_pkg::ST_IDLE;
        end
      end
    endcase

    // Deliver the result, or park it when the output is still full
    if (finish) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
        state_nxt     = prrs_pkg::ST_IDLE;
      end else begin
        res_nxt   = res;
        state_nxt = prrs_pkg::ST_RESP;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= prrs_pkg::ST_CLEAR;
      clr_r        <= '0;
      tick_r       <= '0;
      out_valid_r  <= 1'b0;
      num_levels_r <= prrs_pkg::NUM_LEVELS_W'(1);
      thresh_r     <= '1;
      for (int j = 0; j < MAX_LEVELS; j++) begin
        head_r[j]  <= '0;
        tail_r[j]  <= '0;
        count_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          prrs_pkg::CFG_NUM_LEVELS:   num_levels_r <= cfg_data[prrs_pkg::NUM_LEVELS_W-1:0];
          prrs_pkg::CFG_STARV_THRESH: thresh_r     <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    pick_r     <= pick_nxt;
    hid_r      <= hid_nxt;
  end

  // Link memory: next task in each level's list
  always_ff @(posedge clk) begin
    if (lm_we) begin
      link_mem[lm_wa] <= lm_wd;
    end
    lm_rd_r <= link_mem[lm_ra];
  end

  // Task memory: queued flag and level of the last enqueue or dequeue
  always_ff @(posedge clk) begin
    if (tm_we) begin
      task_mem[tm_wa] <= tm_wd;
    end
    tm_rd_r <= task_mem[tm_ra];
  end

endmodule
